FILE: hw/rtl/lfq_pkg.sv
// shared types and constants for the linked task fifo
// no dependencies
`default_nettype none

package lfq_pkg;

	localparam int THREADS = 16;
	localparam int ID_W    = 4;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;

	typedef logic [ID_W-1:0] id_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_REM  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_QUEUED    = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} state_t;

	typedef struct packed {
		logic rd_en;
		id_t  rd_addr;
		logic wr_en;
		id_t  wr_addr;
		id_t  wr_data;
	} ram_req_t;

	typedef struct packed {
		id_t     result_id;
		status_t status;
		logic    now_empty;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfq_link_ram.sv
// next-link memory, one write and one registered read port
// depends on lfq_pkg
`default_nettype none

module lfq_link_ram (
	input  wire              clk,
	input  lfq_pkg::ram_req_t req,
	output lfq_pkg::id_t      rd_data
);
	import lfq_pkg::*;

	id_t mem_q [THREADS];
	id_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lfq_ctrl.sv
// command sequencer: head, tail, membership bits and list walk
// depends on lfq_pkg, drives lfq_link_ram
`default_nettype none

module lfq_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire [lfq_pkg::CMD_W-1:0] cmd,
	input  lfq_pkg::id_t             thread_id,
	input  wire                      slot_free,
	output logic                     res_valid,
	output lfq_pkg::res_t            res,
	output lfq_pkg::ram_req_t        ram_req,
	input  lfq_pkg::id_t             rd_data
);
	import lfq_pkg::*;

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	id_t                id_q;
	id_t                head_q, head_d;
	id_t                tail_q, tail_d;
	id_t                cur_q, cur_d;
	id_t                prev_q, prev_d;
	logic               has_q, has_d;
	logic [THREADS-1:0] member_q, member_d;
	id_t                cur;

	assign cur      = (state_q == S_WALK) ? cur_q : head_q;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			has_q    <= 1'b0;
			member_q <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			has_q    <= has_d;
			member_q <= member_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= cmd_t'(cmd);
			id_q  <= thread_id;
		end
		cur_q  <= cur_d;
		prev_q <= prev_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					if (cmd_q == CMD_REM && member_q[id_q] && cur != id_q && cur != tail_q) begin
						state_d = S_WALK;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_WALK: begin
				if (slot_free && (cur == id_q || cur == tail_q)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		has_d         = has_q;
		member_d      = member_q;
		cur_d         = cur_q;
		prev_d        = prev_q;
		ram_req       = '0;
		res_valid     = 1'b0;
		res.result_id = '0;
		res.status    = ST_OK;
		res.now_empty = !has_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = head_q;
				end
			end
			S_EXEC: begin
				if (slot_free) begin
					case (cmd_q)
						CMD_ENQ: begin
							res_valid = 1'b1;
							if (member_q[id_q]) begin
								res.status = ST_QUEUED;
							end else begin
								if (has_q) begin
									ram_req.wr_en   = 1'b1;
									ram_req.wr_addr = tail_q;
									ram_req.wr_data = id_q;
								end else begin
									head_d = id_q;
								end
								tail_d         = id_q;
								has_d          = 1'b1;
								member_d[id_q] = 1'b1;
								res.now_empty  = 1'b0;
							end
						end
						CMD_DEQ: begin
							res_valid = 1'b1;
							if (!has_q) begin
								res.status = ST_EMPTY;
							end else begin
								res.result_id = head_q;
								if (head_q == tail_q) begin
									has_d = 1'b0;
								end else begin
									head_d = rd_data;
								end
								member_d[head_q] = 1'b0;
								res.now_empty    = (head_q == tail_q);
							end
						end
						CMD_PEEK: begin
							res_valid = 1'b1;
							if (!has_q) begin
								res.status = ST_EMPTY;
							end else begin
								res.result_id = head_q;
							end
						end
						CMD_REM: begin
							if (!member_q[id_q]) begin
								res_valid  = 1'b1;
								res.status = ST_NOT_FOUND;
							end else if (cur == id_q) begin
								// match at the head
								res_valid = 1'b1;
								if (head_q == tail_q) begin
									has_d = 1'b0;
								end else begin
									head_d = rd_data;
								end
								member_d[id_q] = 1'b0;
								res.now_empty  = (head_q == tail_q);
							end else if (cur == tail_q) begin
								res_valid  = 1'b1;
								res.status = ST_NOT_FOUND;
							end else begin
								prev_d          = cur;
								cur_d           = rd_data;
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = rd_data;
							end
						end
						default: res_valid = 1'b0;
					endcase
				end
			end
			S_WALK: begin
				if (slot_free) begin
					if (cur == id_q) begin
						// unlink from predecessor
						res_valid       = 1'b1;
						ram_req.wr_en   = 1'b1;
						ram_req.wr_addr = prev_q;
						ram_req.wr_data = rd_data;
						if (cur == tail_q) begin
							tail_d = prev_q;
						end
						member_d[id_q] = 1'b0;
					end else if (cur == tail_q) begin
						res_valid  = 1'b1;
						res.status = ST_NOT_FOUND;
					end else begin
						prev_d          = cur;
						cur_d           = rd_data;
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = rd_data;
					end
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/lfq_out_stage.sv
// result register between the sequencer and the output channel
// depends on lfq_pkg
`default_nettype none

module lfq_out_stage (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        res_valid,
	input  lfq_pkg::res_t              res,
	output logic                       slot_free,
	output logic                       out_valid,
	input  wire                        out_stall,
	output lfq_pkg::id_t               result_id,
	output logic [lfq_pkg::STAT_W-1:0] status,
	output logic                       now_empty
);
	import lfq_pkg::*;

	logic valid_q;
	res_t res_q;

	assign slot_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign result_id = res_q.result_id;
	assign status    = res_q.status;
	assign now_empty = res_q.now_empty;

endmodule

`default_nettype wire

FILE: hw/rtl/linked_task_fifo_with_removal.sv
// top level of the linked task fifo with removal
// depends on lfq_pkg, lfq_link_ram, lfq_ctrl, lfq_out_stage
`default_nettype none

// FIFO run queue of 16 thread ids kept as a linked list in a small link
// memory with a registered read port. One command is in flight at a time:
// enqueue, dequeue and peek go from input transfer through the execute
// state to the result; remove walks the list from the head, one read of
// the link memory per hop, until the id or the tail is reached. The result
// sits in an output register, so a new command is taken while a result
// still waits, but a finished command holds until that register is free.
// Reset empties the queue at once; the link memory needs no clearing.

module linked_task_fifo_with_removal (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [lfq_pkg::CMD_W-1:0]   cmd,
	input  wire [lfq_pkg::ID_W-1:0]    thread_id,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [lfq_pkg::ID_W-1:0]   result_id,
	output logic [lfq_pkg::STAT_W-1:0] status,
	output logic                       now_empty
);
	import lfq_pkg::*;

	ram_req_t ram_req;
	id_t      rd_data;
	res_t     res;
	logic     res_valid;
	logic     slot_free;

	lfq_link_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	lfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.thread_id (thread_id),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_req   (ram_req),
		.rd_data   (rd_data)
	);

	lfq_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_id (result_id),
		.status    (status),
		.now_empty (now_empty)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/lfq_chk.sv
// port-level checker for the linked task fifo, with its bind
// depends on lfq_pkg
`default_nettype none

module lfq_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_stall,
	input wire                        out_valid,
	input wire                        out_stall,
	input wire [lfq_pkg::STAT_W-1:0]  status,
	input wire                        now_empty
);
	import lfq_pkg::*;

	default disable iff (!arst_n);

	// one command at a time
	a_one_in_flight: assert property (@(posedge clk)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a command is in flight");

	a_empty_status: assert property (@(posedge clk)
		out_valid && status == ST_EMPTY |-> now_empty)
		else $error("empty status on a non-empty queue");

	a_queued_status: assert property (@(posedge clk)
		out_valid && status == ST_QUEUED |-> !now_empty)
		else $error("already-queued status on an empty queue");

	a_out_hold: assert property (@(posedge clk)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

bind linked_task_fifo_with_removal lfq_chk u_lfq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.now_empty (now_empty)
);

`default_nettype wire

FILE: tb/lfq_checker.sv
`timescale 1ns / 100ps
// checker for the linked task fifo: watches both channels, models the run queue
// and compares every result transfer with the oldest predicted one
// depends on lfq_pkg
module lfq_checker (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_stall,
	input  wire [lfq_pkg::CMD_W-1:0]  cmd,
	input  wire [lfq_pkg::ID_W-1:0]   thread_id,
	input  wire                       out_valid,
	input  wire                       out_stall,
	input  wire [lfq_pkg::ID_W-1:0]   result_id,
	input  wire [lfq_pkg::STAT_W-1:0] status,
	input  wire                       now_empty,
	output int                        errors,
	output int                        pending
);
	import lfq_pkg::*;

	id_t               link_of [THREADS];
	logic [THREADS-1:0] in_list;
	id_t               head_ptr;
	id_t               tail_ptr;
	logic              nonempty;
	res_t              queue_answers [$];
	res_t              want;

	initial errors = 0;
	initial pending = 0;

	function automatic res_t apply_queue_cmd(cmd_t op, id_t id);
		res_t r;
		id_t  cur;
		id_t  prev;
		logic have_prev;
		logic done;
		int   s;
		r.result_id = '0;
		r.status    = ST_OK;
		case (op)
			CMD_ENQ: begin
				if (in_list[id]) begin
					r.status = ST_QUEUED;
				end else begin
					if (nonempty)
						link_of[tail_ptr] = id;
					else
						head_ptr = id;
					tail_ptr    = id;
					link_of[id] = '0;
					in_list[id] = 1'b1;
					nonempty    = 1'b1;
				end
			end
			CMD_DEQ: begin
				if (!nonempty) begin
					r.status = ST_EMPTY;
				end else begin
					r.result_id = head_ptr;
					if (head_ptr == tail_ptr)
						nonempty = 1'b0;
					else
						head_ptr = link_of[head_ptr];
					link_of[r.result_id] = '0;
					in_list[r.result_id] = 1'b0;
				end
			end
			CMD_PEEK: begin
				if (!nonempty)
					r.status = ST_EMPTY;
				else
					r.result_id = head_ptr;
			end
			CMD_REM: begin
				r.status = ST_NOT_FOUND;
				if (in_list[id] && nonempty) begin
					cur       = head_ptr;
					prev      = '0;
					have_prev = 1'b0;
					done      = 1'b0;
					for (s = 0; s < THREADS && !done; s++) begin
						if (cur == id) begin
							if (!have_prev) begin
								if (head_ptr == tail_ptr)
									nonempty = 1'b0;
								else
									head_ptr = link_of[cur];
							end else begin
								link_of[prev] = link_of[cur];
								if (cur == tail_ptr)
									tail_ptr = prev;
							end
							link_of[cur] = '0;
							in_list[id]  = 1'b0;
							r.status     = ST_OK;
							done         = 1'b1;
						end else if (cur == tail_ptr) begin
							done = 1'b1;
						end else begin
							prev      = cur;
							have_prev = 1'b1;
							cur       = link_of[cur];
						end
					end
				end
			end
			default: ;
		endcase
		r.now_empty = !nonempty;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_list  = '0;
			head_ptr = '0;
			tail_ptr = '0;
			nonempty = 1'b0;
			queue_answers.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (queue_answers.size() == 0) begin
					$error("result transfer with no command outstanding");
					errors++;
				end else begin
					want = queue_answers.pop_front();
					if (result_id !== want.result_id) begin
						$error("result_id: expected %0d, got %0d", want.result_id, result_id);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (now_empty !== want.now_empty) begin
						$error("now_empty: expected %0d, got %0d", want.now_empty, now_empty);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				queue_answers.push_back(apply_queue_cmd(cmd_t'(cmd), thread_id));
			pending <= queue_answers.size();
		end
	end

endmodule

FILE: tb/tb_linked_task_fifo_with_removal.sv
`timescale 1ns / 100ps
// testbench top for the linked task fifo: directed and random command streams
// under varying idle and stall patterns; depends on lfq_pkg, lfq_checker and the block
module tb_linked_task_fifo_with_removal;
	import lfq_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	wire                in_stall;
	cmd_t               cmd = CMD_ENQ;
	id_t                thread_id = '0;
	wire                out_valid;
	logic               out_stall = 1'b0;
	wire  [ID_W-1:0]    result_id;
	wire  [STAT_W-1:0]  status;
	wire                now_empty;
	int                 errors;
	int                 pending;

	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	logic               hold_off = 1'b0;
	bit                 pressure_on = 1'b0;
	logic [THREADS-1:0] listed = '0;
	int                 order_q [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	linked_task_fifo_with_removal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.thread_id (thread_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_id (result_id),
		.status    (status),
		.now_empty (now_empty)
	);

	lfq_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.thread_id (thread_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_id (result_id),
		.status    (status),
		.now_empty (now_empty),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (pressure_on);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
	endtask

	task automatic send_cmd(input cmd_t op, input id_t id);
		int k;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		thread_id <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// track membership and order to steer later picks
		case (op)
			CMD_ENQ: begin
				if (!listed[id]) begin
					order_q.push_back(id);
					listed[id] = 1'b1;
				end
			end
			CMD_DEQ: begin
				if (order_q.size() > 0)
					listed[order_q.pop_front()] = 1'b0;
			end
			CMD_REM: begin
				if (listed[id]) begin
					for (k = 0; k < order_q.size(); k++)
						if (order_q[k] == id) begin
							order_q.delete(k);
							break;
						end
					listed[id] = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_random(input bit filling);
		int   r;
		cmd_t op;
		id_t  id;
		r = $urandom_range(0, 99);
		if (filling)
			op = cmd_t'(r < 55 ? CMD_ENQ : r < 65 ? CMD_DEQ : r < 75 ? CMD_PEEK : CMD_REM);
		else
			op = cmd_t'(r < 25 ? CMD_ENQ : r < 55 ? CMD_DEQ : r < 65 ? CMD_PEEK : CMD_REM);
		id = id_t'($urandom_range(0, THREADS - 1));
		if ($urandom_range(0, 99) < 85) begin
			if (op == CMD_ENQ && listed != '1) begin
				while (listed[id])
					id = id_t'($urandom_range(0, THREADS - 1));
			end else if (op == CMD_REM && order_q.size() > 0) begin
				id = id_t'(order_q[$urandom_range(0, order_q.size() - 1)]);
			end
		end
		send_cmd(op, id);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_PEEK, 4'd9);
		send_cmd(CMD_DEQ, 4'd15);
		send_cmd(CMD_REM, 4'd15);
		send_cmd(CMD_ENQ, 4'd0);
		send_cmd(CMD_ENQ, 4'd15);
		send_cmd(CMD_ENQ, 4'd0);
		send_cmd(CMD_PEEK, 4'd0);
		send_cmd(CMD_ENQ, 4'd5);
		send_cmd(CMD_ENQ, 4'd10);
		send_cmd(CMD_REM, 4'd15);
		send_cmd(CMD_REM, 4'd10);
		send_cmd(CMD_ENQ, 4'd9);
		send_cmd(CMD_REM, 4'd0);
		send_cmd(CMD_REM, 4'd3);
		send_cmd(CMD_DEQ, 4'd6);
		send_cmd(CMD_DEQ, 4'd0);
		send_cmd(CMD_ENQ, 4'd7);
		send_cmd(CMD_REM, 4'd7);
		send_cmd(CMD_PEEK, 4'd15);
		send_cmd(CMD_ENQ, 4'd1);
		send_cmd(CMD_ENQ, 4'd2);
		send_cmd(CMD_DEQ, 4'd12);
		send_cmd(CMD_DEQ, 4'd3);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(51, 0);
				2: set_idling(0, 51);
				default: set_idling(36, 36);
			endcase
			if (phase == 0)
				pressure_on = 1'b1;
			for (int i = 0; i < 300; i++)
				send_random(((i / 50) % 2) == 0);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
